// ===== hdl/efst_pkg.sv =====
// Shared types and constants for the encoder frame speed tracker.
`default_nettype none

package efst_pkg;

    // Widths of the speed divider operands.
    localparam int DIVD_W = 25;  // magnitude of delta*1000 stays below 2^25
    localparam int DIVR_W = 16;  // interval in ms, low 16 bits

    // Request kinds
    typedef enum logic {
        KIND_POLL = 1'b0,
        KIND_BYTE = 1'b1
    } t_item_kind;

    // Configuration register indexes
    typedef enum logic {
        CFG_STATION   = 1'b0,
        CFG_REG_COUNT = 1'b1
    } t_cfg_index;

    // Function code of a holding-register read reply
    localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;

    // Status of the divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

`default_nettype wire

// ===== hdl/encoder_frame_speed_tracker.sv =====
// Top level: reply byte collection, frame checks, angle tracking and speed sequencer.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------------
//  in      | in        | i_in_valid / o_in_ready | i_kind, i_rx_byte, i_now_ms
//  out     | out       | o_out_valid/i_out_ready | o_frame_accepted .. o_fail_count
//  cfg     | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// A request that starts no division goes from the evaluate state to the output state.
// A reply accepted with a nonzero interval goes through the evaluate, multiply and
// divider start states, then 25 steps of the restoring divider and its done
// cycle. One request is in flight at a time; o_in_ready is low until the result
// is taken. Reset is synchronous and active low; all tracked values return to zero,
// the station address and register count to one. Configuration writes are always taken.
`default_nettype none

module encoder_frame_speed_tracker #(
    parameter int ANGLE_SPAN = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input requests
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_kind,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [31:0] i_now_ms,
    // results
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_frame_accepted,
    output logic [15:0]      o_angle,
    output logic signed [15:0] o_angle_delta,
    output logic [15:0]      o_interval_ms,
    output logic signed [15:0] o_speed,
    output logic [15:0]      o_revolutions,
    output logic [15:0]      o_success_count,
    output logic [15:0]      o_fail_count,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    localparam int          HEADER_DEPTH      = 5;
    localparam int          HDR_IDX_W         = $clog2(HEADER_DEPTH);
    localparam logic [16:0] ANGLE_LO          = 17'(ANGLE_SPAN / 4);
    localparam logic [16:0] ANGLE_HI          = 17'(3 * (ANGLE_SPAN / 4));
    localparam logic [17:0] SPAN18            = 18'(ANGLE_SPAN);
    localparam logic signed [26:0] SPEED_SCALE = 27'sd1000;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EVAL  = 6'b000010,
        S_MUL   = 6'b000100,
        S_START = 6'b001000,
        S_DIV   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state;

    // Configuration
    logic [7:0]  r_station;
    logic [6:0]  r_reg_count;

    // Captured request
    logic        r_kind;
    logic [7:0]  r_rx;
    logic [15:0] r_now;

    // Collection state
    logic [7:0]  r_byte_index;
    logic        r_awaiting;
    logic [7:0]  r_header [HEADER_DEPTH];

    // Tracked values
    logic [15:0] r_angle;
    logic [15:0] r_prev_stamp;
    logic [15:0] r_delta;
    logic [15:0] r_interval;
    logic [15:0] r_speed;
    logic [15:0] r_revs;
    logic [15:0] r_good;
    logic [15:0] r_missed;
    logic        r_accepted;

    logic signed [26:0] r_prod;

    // Evaluation of the captured request
    logic [7:0]  n_byte_index;
    logic [8:0]  reply_len;
    logic        complete;
    logic        header_ok;
    logic        take;
    logic [7:0]  hdr_last;
    logic [15:0] n_angle;
    logic [15:0] n_interval;
    logic [17:0] n_delta;
    logic        fwd_wrap;
    logic        bwd_wrap;

    // Divider hookup
    logic                        div_start;
    logic                        prod_neg;
    logic [26:0]                 prod_mag;
    logic [15:0]                 quo16;
    efst_pkg::t_div_status       div_status;
    logic [efst_pkg::DIVD_W-1:0] div_quotient;

    // Byte count, frame checks and angle delta
    always_comb begin
        n_byte_index = (r_byte_index != 8'hFF) ? r_byte_index + 8'd1 : r_byte_index;
        reply_len    = {1'b0, r_reg_count, 1'b0} + 9'd5;
        complete     = ({1'b0, n_byte_index} >= reply_len);
        header_ok    = (r_header[0] == r_station)
                    && (r_header[1] == efst_pkg::FUNC_READ_HOLDING)
                    && (r_header[2] == {r_reg_count, 1'b0});
        take         = r_kind && complete && header_ok;
        // the byte that closes a header-only reply is not stored yet
        hdr_last     = (r_byte_index == 8'(HEADER_DEPTH - 1)) ? r_rx
                                                               : r_header[HEADER_DEPTH-1];
        n_angle      = {r_header[3], hdr_last};
        n_interval   = r_now - r_prev_stamp;
        fwd_wrap     = ({1'b0, n_angle} < ANGLE_LO) && ({1'b0, r_angle} > ANGLE_HI);
        bwd_wrap     = ({1'b0, n_angle} > ANGLE_HI) && ({1'b0, r_angle} < ANGLE_LO);
        n_delta      = {2'b00, n_angle} - {2'b00, r_angle};
        if (fwd_wrap) begin
            n_delta = n_delta + SPAN18;
        end else if (bwd_wrap) begin
            n_delta = n_delta - SPAN18;
        end
    end

    // Sign and magnitude around the divider
    always_comb begin
        prod_neg  = r_prod[26];
        prod_mag  = prod_neg ? (~r_prod + 27'd1) : r_prod;
        div_start = (r_state == S_START);
        quo16     = div_quotient[15:0];
    end

    efst_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (prod_mag[efst_pkg::DIVD_W-1:0]),
        .i_divisor  (r_interval),
        .o_status   (div_status),
        .o_quotient (div_quotient)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station   <= 8'd1;
            r_reg_count <= 7'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                efst_pkg::CFG_STATION:   r_station   <= i_cfg_data;
                efst_pkg::CFG_REG_COUNT: r_reg_count <= i_cfg_data[6:0];
                default:                 r_station   <= r_station;
            endcase
        end
    end

    // Request capture, header store and product
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_kind <= i_kind;
            r_rx   <= i_rx_byte;
            r_now  <= i_now_ms[15:0];
        end
        if (r_state == S_EVAL && r_kind && r_byte_index < 8'(HEADER_DEPTH)) begin
            r_header[r_byte_index[HDR_IDX_W-1:0]] <= r_rx;
        end
        if (r_state == S_MUL) begin
            r_prod <= $signed({{11{r_delta[15]}}, r_delta}) * SPEED_SCALE;
        end
    end

    // Sequencer and tracked state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_byte_index <= '0;
            r_awaiting   <= 1'b0;
            r_angle      <= '0;
            r_prev_stamp <= '0;
            r_delta      <= '0;
            r_interval   <= '0;
            r_speed      <= '0;
            r_revs       <= '0;
            r_good       <= '0;
            r_missed     <= '0;
            r_accepted   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_accepted <= take;
                    r_state    <= S_OUT;
                    if (r_kind == efst_pkg::KIND_POLL) begin
                        if (r_awaiting) begin
                            r_missed <= r_missed + 16'd1;
                        end
                        r_byte_index <= '0;
                        r_awaiting   <= 1'b1;
                    end else if (take) begin
                        r_angle      <= n_angle;
                        r_interval   <= n_interval;
                        r_prev_stamp <= r_now;
                        r_delta      <= n_delta[15:0];
                        if (fwd_wrap) begin
                            r_revs <= r_revs + 16'd1;
                        end else if (bwd_wrap) begin
                            r_revs <= r_revs - 16'd1;
                        end
                        r_good       <= r_good + 16'd1;
                        r_awaiting   <= 1'b0;
                        r_byte_index <= '0;
                        if (n_interval != 16'd0) begin
                            r_state <= S_MUL;
                        end
                    end else begin
                        r_byte_index <= n_byte_index;
                    end
                end
                S_MUL: begin
                    r_state <= S_START;
                end
                S_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_status.done) begin
                        r_speed <= prod_neg ? (16'd0 - quo16) : quo16;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Ports
    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = (r_state == S_OUT);
    assign o_cfg_ready      = 1'b1;
    assign o_frame_accepted = r_accepted;
    assign o_angle          = r_angle;
    assign o_angle_delta    = r_delta;
    assign o_interval_ms    = r_interval;
    assign o_speed          = r_speed;
    assign o_revolutions    = r_revs;
    assign o_success_count  = r_good;
    assign o_fail_count     = r_missed;

`ifndef NO_ASSERTIONS
    // An accepted reply bumps the success count by one
    a_good_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && take) |=> (r_good == $past(r_good) + 16'd1))
        else $error("success count not advanced on accepted reply");

    // A poll never reports an accepted frame
    a_poll_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && r_kind == efst_pkg::KIND_POLL) |=> !r_accepted)
        else $error("poll reported as accepted frame");

    // A delivered accepted frame leaves no reply pending
    a_frame_clears_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_accepted) |-> (!r_awaiting && r_byte_index == 8'd0))
        else $error("accepted frame left collection open");

    // The divider is only running while the sequencer waits on it
    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_status.busy |-> (r_state == S_DIV))
        else $error("divider busy outside divide state");
`endif

endmodule

`default_nettype wire

// ===== hdl/efst_div.sv =====
// Iterative unsigned restoring divider, one quotient bit per cycle.
`default_nettype none

module efst_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [efst_pkg::DIVD_W-1:0]  i_dividend,
    input  wire logic [efst_pkg::DIVR_W-1:0]  i_divisor,
    output efst_pkg::t_div_status             o_status,
    output logic      [efst_pkg::DIVD_W-1:0]  o_quotient
);

    localparam int STEPS = efst_pkg::DIVD_W;
    localparam int CNT_W = $clog2(STEPS);

    logic                         r_busy;
    logic                         r_done;
    logic [CNT_W-1:0]             r_cnt;
    logic [efst_pkg::DIVR_W-1:0]  r_rem;
    logic [efst_pkg::DIVD_W-1:0]  r_quo;
    logic [efst_pkg::DIVR_W-1:0]  r_divisor;

    logic [efst_pkg::DIVR_W:0]    rem_sh;
    logic [efst_pkg::DIVR_W:0]    rem_diff;
    logic                         fits;

    // One restoring step: shift in the next dividend bit, try the subtract
    always_comb begin
        rem_sh   = {r_rem, r_quo[efst_pkg::DIVD_W-1]};
        rem_diff = rem_sh - {1'b0, r_divisor};
        fits     = (rem_sh >= {1'b0, r_divisor});
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath: r_quo holds the remaining dividend bits and collects quotient bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_quo     <= i_dividend;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? rem_diff[efst_pkg::DIVR_W-1:0] : rem_sh[efst_pkg::DIVR_W-1:0];
            r_quo <= {r_quo[efst_pkg::DIVD_W-2:0], fits};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quo;

`ifndef NO_ASSERTIONS
    // A new division never starts on top of one in flight
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

    // Done is raised in the cycle after the last step
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && r_cnt == CNT_W'(STEPS - 1)) |=> (r_done && !r_busy))
        else $error("divider done not raised after last step");

    // Done is a single-cycle pulse
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !i_start) |=> !r_done)
        else $error("divider done held longer than one cycle");
`endif

endmodule

`default_nettype wire

// ===== tb/encoder_frame_speed_tracker_test.sv =====
// Testbench for the encoder frame speed tracker: scripted and random requests.
`timescale 1ns / 1ps

module encoder_frame_speed_tracker_test;

    localparam int ANGLE_SPAN    = 4096;
    localparam int SPAN_LO       = ANGLE_SPAN / 4;
    localparam int SPAN_HI       = 3 * (ANGLE_SPAN / 4);
    localparam int SPEED_SCALE   = 1000;
    localparam int HDR_DEPTH     = 5;
    localparam int STALL_LIMIT   = 4000;  // cycles without any handshake
    localparam int SETTLE_CYCLES = 40;    // covers the divider path with margin
    localparam int LONG_HOLD     = 300;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} t_rx_mode;

    typedef struct packed {
        logic        accepted;
        logic [15:0] angle;
        logic [15:0] delta;
        logic [15:0] ivl;
        logic [15:0] speed;
        logic [15:0] revs;
        logic [15:0] good;
        logic [15:0] missed;
    } t_tracker_reading;

    typedef struct packed {
        efst_pkg::t_item_kind kind;
        logic [7:0]           rx;
        logic [31:0]          stamp;
        logic                 typed;
        t_tracker_reading     want;
    } t_script_row;

    // DUT connections
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    efst_pkg::t_item_kind i_kind = efst_pkg::KIND_POLL;
    logic [7:0]        i_rx_byte = 8'h00;
    logic [31:0]       i_now_ms = 32'h0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic              o_frame_accepted;
    logic [15:0]       o_angle;
    logic signed [15:0] o_angle_delta;
    logic [15:0]       o_interval_ms;
    logic signed [15:0] o_speed;
    logic [15:0]       o_revolutions;
    logic [15:0]       o_success_count;
    logic [15:0]       o_fail_count;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    efst_pkg::t_cfg_index i_cfg_index = efst_pkg::CFG_STATION;
    logic [7:0]        i_cfg_data = 8'h00;

    // tracker state as predicted
    logic [7:0]  cfg_station = 8'd1;
    logic [6:0]  cfg_regs = 7'd1;
    int          seen_bytes = 0;
    logic        poll_open = 1'b0;
    logic [7:0]  hdr_bytes [HDR_DEPTH];
    logic [15:0] last_angle = '0;
    logic [31:0] last_stamp = '0;
    logic [15:0] last_delta = '0;
    logic [15:0] last_ivl = '0;
    logic [15:0] last_speed = '0;
    logic [15:0] rev_count = '0;
    logic [15:0] good_count = '0;
    logic [15:0] missed_count = '0;

    t_tracker_reading pending_readings [$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          quiet_cycles = 0;
    logic [31:0] clock_ms = 32'd0;

    // traffic shaping
    logic        gaps_on = 1'b1;
    int          burst_left = 0;
    t_rx_mode    rx_mode = RX_RANDOM;
    logic [7:0]  rx_pattern = 8'b1011_0111;
    logic [2:0]  rx_pos = '0;
    int          holds_asked = 0;
    int          holds_served = 0;
    int          hold_left = 0;

    // scripted opening: default station 1, one register, so a reply is 7 bytes
    t_script_row script [25] = '{
        '{efst_pkg::KIND_POLL, 8'h00, 32'd0,   1'b1, '{1'b0, 16'd0, 16'd0, 16'd0, 16'd0,
                                                      16'd0, 16'd0, 16'd0}},
        // second poll with no reply in between counts a failure
        '{efst_pkg::KIND_POLL, 8'h00, 32'd5,   1'b1, '{1'b0, 16'd0, 16'd0, 16'd0, 16'd0,
                                                      16'd0, 16'd0, 16'd1}},
        '{efst_pkg::KIND_BYTE, 8'h01, 32'd100, 1'b0, '0},
        '{efst_pkg::KIND_BYTE, 8'h03, 32'd100, 1'b0, '0},
        '{efst_pkg::KIND_BYTE, 8'h02, 32'd100, 1'b0, '0},
        '{efst_pkg::KIND_BYTE, 8'h0F, 32'd100, 1'b0, '0},
        '{efst_pkg::KIND_BYTE, 8'hFF, 32'd100, 1'b0, '0},
        '{efst_pkg::KIND_BYTE, 8'hAB, 32'd100, 1'b0, '0},
        // angle 4095 after 0: backward wrap, delta -1, speed -10
        '{efst_pkg::KIND_BYTE, 8'hCD, 32'd100, 1'b1, '{1'b1, 16'd4095, 16'hFFFF, 16'd100,
                                                      16'hFFF6, 16'hFFFF, 16'd1, 16'd1}},
        // reply without a poll, angle 0: forward wrap, interval 65536 wraps to zero
        '{efst_pkg::KIND_BYTE, 8'h01, 32'd200, 1'b0, '0},
        '{efst_pkg::KIND_BYTE, 8'h03, 32'd200, 1'b0, '0},
        '{efst_pkg::KIND_BYTE, 8'h02, 32'd200, 1'b0, '0},
        '{efst_pkg::KIND_BYTE, 8'h00, 32'd200, 1'b0, '0},
        '{efst_pkg::KIND_BYTE, 8'h00, 32'd200, 1'b0, '0},
        '{efst_pkg::KIND_BYTE, 8'h55, 32'd200, 1'b0, '0},
        '{efst_pkg::KIND_BYTE, 8'hAA, 32'd65636, 1'b1, '{1'b1, 16'd0, 16'd1, 16'd0,
                                                        16'hFFF6, 16'd0, 16'd2, 16'd1}},
        // bad function code, then one extra byte repeats the failing check
        '{efst_pkg::KIND_POLL, 8'hFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{efst_pkg::KIND_BYTE, 8'h01, 32'hFFFF_FFFF, 1'b0, '0},
        '{efst_pkg::KIND_BYTE, 8'h10, 32'hFFFF_FFFF, 1'b0, '0},
        '{efst_pkg::KIND_BYTE, 8'h02, 32'hFFFF_FFFF, 1'b0, '0},
        '{efst_pkg::KIND_BYTE, 8'hFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{efst_pkg::KIND_BYTE, 8'hFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{efst_pkg::KIND_BYTE, 8'h00, 32'hFFFF_FFFF, 1'b0, '0},
        '{efst_pkg::KIND_BYTE, 8'hFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{efst_pkg::KIND_BYTE, 8'hFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 16'd0, 16'd1, 16'd0,
                                                            16'hFFF6, 16'd0, 16'd2, 16'd1}}
    };

    encoder_frame_speed_tracker #(
        .ANGLE_SPAN(ANGLE_SPAN)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_rx_byte       (i_rx_byte),
        .i_now_ms        (i_now_ms),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_frame_accepted(o_frame_accepted),
        .o_angle         (o_angle),
        .o_angle_delta   (o_angle_delta),
        .o_interval_ms   (o_interval_ms),
        .o_speed         (o_speed),
        .o_revolutions   (o_revolutions),
        .o_success_count (o_success_count),
        .o_fail_count    (o_fail_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Advance the tracker state by one request and return the reading it yields.
    function automatic t_tracker_reading predict_reading(efst_pkg::t_item_kind kind,
                                                         logic [7:0] rx, logic [31:0] now);
        t_tracker_reading r;
        int old_ang, new_ang, turn, quot;
        logic took;
        took = 1'b0;
        if (kind == efst_pkg::KIND_POLL) begin
            if (poll_open)
                missed_count = missed_count + 16'd1;
            seen_bytes = 0;
            poll_open = 1'b1;
        end else begin
            if (seen_bytes < HDR_DEPTH)
                hdr_bytes[seen_bytes] = rx;
            if (seen_bytes < 255)
                seen_bytes++;
            if (seen_bytes >= 2 * cfg_regs + 5 && hdr_bytes[0] == cfg_station &&
                hdr_bytes[1] == efst_pkg::FUNC_READ_HOLDING &&
                hdr_bytes[2] == 8'(2 * cfg_regs)) begin
                took = 1'b1;
                old_ang = last_angle;
                new_ang = {hdr_bytes[3], hdr_bytes[4]};
                last_angle = 16'(new_ang);
                last_ivl = 16'(now - last_stamp);
                last_stamp = now;
                turn = new_ang - old_ang;
                // wrap correction moves the revolution count
                if (new_ang < SPAN_LO && old_ang > SPAN_HI) begin
                    turn = turn + ANGLE_SPAN;
                    rev_count = rev_count + 16'd1;
                end
                if (new_ang > SPAN_HI && old_ang < SPAN_LO) begin
                    turn = turn - ANGLE_SPAN;
                    rev_count = rev_count - 16'd1;
                end
                last_delta = 16'(turn);
                // speed held on a zero interval
                if (last_ivl != 16'd0) begin
                    quot = int'($signed(last_delta)) * SPEED_SCALE / int'(last_ivl);
                    last_speed = 16'(quot);
                end
                good_count = good_count + 16'd1;
                poll_open = 1'b0;
                seen_bytes = 0;
            end
        end
        r = '{took, last_angle, last_delta, last_ivl, last_speed, rev_count, good_count,
              missed_count};
        return r;
    endfunction

    function automatic logic [31:0] next_stamp();
        case ($urandom_range(0, 9))
            0: ;                                          // same millisecond
            1: clock_ms = $urandom;                       // jump anywhere
            default: clock_ms = clock_ms + $urandom_range(1, 300);
        endcase
        return clock_ms;
    endfunction

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(0, 6))
            0, 1: return 16'($urandom_range(0, ANGLE_SPAN - 1));
            2: return 16'($urandom_range(0, SPAN_LO - 1));
            3: return 16'($urandom_range(SPAN_HI + 1, ANGLE_SPAN - 1));
            4: return 16'($urandom_range(0, 65535));
            5: return 16'(last_angle + $urandom_range(0, 64) - 32);
            default: begin
                case ($urandom_range(0, 5))
                    0: return 16'(SPAN_LO - 1);
                    1: return 16'(SPAN_LO);
                    2: return 16'(SPAN_HI);
                    3: return 16'(SPAN_HI + 1);
                    4: return 16'd0;
                    default: return 16'(ANGLE_SPAN - 1);
                endcase
            end
        endcase
    endfunction

    // Offer one request, honoring the burst/gap shaping, and log its expected reading.
    task automatic push_item(efst_pkg::t_item_kind kind, logic [7:0] rx, logic [31:0] stamp);
        if (gaps_on && burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_rx_byte <= rx;
        i_now_ms <= stamp;
        do @(posedge i_clk); while (!o_in_ready);
        pending_readings.push_back(predict_reading(kind, rx, stamp));
        items_sent++;
    endtask

    // Optional poll, then a reply with the given header fields and total length.
    task automatic send_frame(logic with_poll, logic [7:0] addr, logic [7:0] func,
                              logic [7:0] count, logic [15:0] ang, int len);
        logic [7:0]  b;
        logic [31:0] t;
        if (with_poll)
            push_item(efst_pkg::KIND_POLL, 8'($urandom), next_stamp());
        for (int i = 0; i < len; i++) begin
            case (i)
                0: b = addr;
                1: b = func;
                2: b = count;
                3: b = ang[15:8];
                4: b = ang[7:0];
                default: b = 8'($urandom);
            endcase
            t = next_stamp();
            // sometimes land the closing byte on a zero interval
            if (i == len - 1 && $urandom_range(0, 6) == 0)
                t = last_stamp + 32'($urandom_range(0, 3)) * 32'h1_0000;
            push_item(efst_pkg::KIND_BYTE, b, t);
        end
    endtask

    // One register write, with valid dropped and the port left quiet before anything else drives it.
    task automatic write_reg(efst_pkg::t_cfg_index idx, logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == efst_pkg::CFG_STATION)
            cfg_station = data;
        else
            cfg_regs = data[6:0];
        @(posedge i_clk);
    endtask

    // Drop valid, drain every outstanding reading, then let the datapath go quiet.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly well-formed replies, plus broken headers, short replies and noise.
    task automatic run_phase(int budget);
        int         start, sel, frame_len, which;
        logic [7:0] flip, count_ok;
        start = items_sent;
        frame_len = 2 * cfg_regs + 5;
        count_ok = 8'(2 * cfg_regs);
        while (items_sent - start < budget) begin
            sel = $urandom_range(0, 99);
            if (sel < 65) begin
                send_frame(1'b1, cfg_station, efst_pkg::FUNC_READ_HOLDING, count_ok,
                           pick_angle(), frame_len);
            end else if (sel < 75) begin
                send_frame(1'b0, cfg_station, efst_pkg::FUNC_READ_HOLDING, count_ok,
                           pick_angle(), frame_len);
            end else if (sel < 87) begin
                flip = 8'($urandom_range(1, 255));
                which = $urandom_range(0, 2);
                send_frame(1'b1, (which == 0) ? cfg_station ^ flip : cfg_station,
                           (which == 1) ? efst_pkg::FUNC_READ_HOLDING ^ flip
                                        : efst_pkg::FUNC_READ_HOLDING,
                           (which == 2) ? count_ok ^ flip : count_ok,
                           pick_angle(), frame_len + $urandom_range(0, 3));
            end else if (sel < 94) begin
                send_frame(1'b1, cfg_station, efst_pkg::FUNC_READ_HOLDING, count_ok,
                           pick_angle(), $urandom_range(0, frame_len - 1));
            end else begin
                repeat ($urandom_range(1, 4))
                    push_item(efst_pkg::t_item_kind'($urandom_range(0, 1)), 8'($urandom),
                              next_stamp());
            end
        end
        settle();
    endtask

    task automatic match_field(string name, logic signed [31:0] want_v,
                               logic signed [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatches++;
        end
    endtask

    task automatic check_reading();
        t_tracker_reading want;
        if (pending_readings.size() == 0) begin
            $error("result with no request outstanding");
            mismatches++;
        end else begin
            want = pending_readings.pop_front();
            match_field("frame_accepted", want.accepted, o_frame_accepted);
            match_field("angle", want.angle, o_angle);
            match_field("angle_delta", $signed(want.delta), o_angle_delta);
            match_field("interval_ms", want.ivl, o_interval_ms);
            match_field("speed", $signed(want.speed), o_speed);
            match_field("revolutions", want.revs, o_revolutions);
            match_field("success_count", want.good, o_success_count);
            match_field("fail_count", want.missed, o_fail_count);
        end
    endtask

    // Result side: check accepted readings, then pick next cycle's ready.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            check_reading();
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = LONG_HOLD - 1;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: i_out_ready <= 1'b1;
                RX_RANDOM: i_out_ready <= ($urandom_range(0, 3) != 0);
                default: begin
                    i_out_ready <= rx_pattern[rx_pos];
                    rx_pos = rx_pos + 3'd1;
                end
            endcase
        end
    end

    // Watchdog: any handshake restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("[encoder_frame_speed_tracker] ERROR");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < HDR_DEPTH; i++)
            hdr_bytes[i] = 8'h00;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // scripted opening on reset configuration
        for (int r = 0; r < 25; r++) begin
            push_item(script[r].kind, script[r].rx, script[r].stamp);
            if (script[r].typed)
                pending_readings[$] = script[r].want;
        end
        settle();

        // configuration sweep, each setting followed by its own traffic
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_reg(efst_pkg::CFG_STATION, 8'h00);
                    write_reg(efst_pkg::CFG_REG_COUNT, 8'h81);  // top bit is dropped
                    gaps_on = 1'b1;
                    rx_mode = RX_RANDOM;
                    run_phase(140);
                end
                1: begin
                    // receiver holds off while requests keep coming
                    write_reg(efst_pkg::CFG_STATION, 8'hFF);
                    write_reg(efst_pkg::CFG_REG_COUNT, 8'h02);
                    gaps_on = 1'b0;
                    rx_mode = RX_ALWAYS;
                    holds_asked++;
                    run_phase(140);
                end
                2: begin
                    // longest reply that still completes: 255 bytes
                    write_reg(efst_pkg::CFG_STATION, 8'h5A);
                    write_reg(efst_pkg::CFG_REG_COUNT, 8'hFD);
                    gaps_on = 1'b1;
                    rx_mode = RX_PATTERN;
                    send_frame(1'b1, cfg_station, efst_pkg::FUNC_READ_HOLDING, 8'd250,
                               pick_angle(), 255);
                    push_item(efst_pkg::KIND_POLL, 8'($urandom), next_stamp());
                    settle();
                end
                3: begin
                    // reply length beyond the saturating byte counter never completes
                    write_reg(efst_pkg::CFG_STATION, 8'($urandom));
                    write_reg(efst_pkg::CFG_REG_COUNT, 8'h7F);
                    gaps_on = 1'b0;
                    rx_mode = RX_RANDOM;
                    send_frame(1'b1, cfg_station, efst_pkg::FUNC_READ_HOLDING, 8'd254,
                               pick_angle(), 260);
                    push_item(efst_pkg::KIND_POLL, 8'($urandom), next_stamp());
                    settle();
                end
                4: begin
                    // zero registers: header-only replies
                    write_reg(efst_pkg::CFG_STATION, 8'($urandom));
                    write_reg(efst_pkg::CFG_REG_COUNT, 8'h80);
                    gaps_on = 1'b1;
                    rx_mode = RX_ALWAYS;
                    run_phase(120);
                end
                default: begin
                    write_reg(efst_pkg::CFG_STATION, 8'($urandom));
                    write_reg(efst_pkg::CFG_REG_COUNT,
                              {1'($urandom), 7'($urandom_range(1, 4))});
                    gaps_on = 1'($urandom);
                    rx_mode = t_rx_mode'($urandom_range(0, 2));
                    rx_pattern = 8'($urandom) | 8'h01;
                    run_phase(140);
                end
            endcase
        end

        if (mismatches == 0)
            $display("[encoder_frame_speed_tracker] OK");
        else
            $display("[encoder_frame_speed_tracker] ERROR");
        $finish;
    end

endmodule
